// ===== rtl/ubds_pkg.sv =====
// Package for the UART baud divisor search unit: widths, constants and types.
// Used by ubds_divider, ubds_error_pipe and uart_baud_divisor_search_unit.
package ubds_pkg;
   localparam int RateWidth     = 26;
   localparam int PrescWidth    = 16;
   localparam int PatWidth      = 8;
   localparam int PatternCount  = 256;
   localparam int DefBitsFrame  = 11;
   localparam int PlainLimit    = 20;
   localparam logic [RateWidth-1:0] ClockReset = 26'd3000000;
   // Worst error: (i+1)*clock and count*baud stay below 2^26 * 2^24.
   localparam int ErrWidth      = 50;
   localparam int CountWidth    = 20;
   localparam int QuoWidth      = 26;

   typedef struct packed {
      logic                  valid;
      logic [QuoWidth-1:0]   quo;
   } div_res_type;
endpackage

// ===== rtl/ubds_divider.sv =====
// Bit-serial restoring divider: clock / baud, one quotient bit per cycle.
// Depends on ubds_pkg.
module ubds_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ubds_pkg::RateWidth-1:0] dividend,
   input  logic [ubds_pkg::RateWidth-1:0] divisor,
   output ubds_pkg::div_res_type         result
);
   import ubds_pkg::*;

   logic [RateWidth-1:0] rem_ff, rem_in;
   logic [QuoWidth-1:0]  quo_ff, quo_in;
   logic [RateWidth-1:0] dvd_ff, dvd_in;
   logic [RateWidth-1:0] dvs_ff, dvs_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [RateWidth:0]   trial;

   // The partial remainder is always below the divisor, so it fits the rate width.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[RateWidth-1]};
      if (start) begin
         rem_in = '0;
         quo_in = '0;
         dvd_in = dividend;
         dvs_in = divisor;
         cnt_in = 5'(RateWidth - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[RateWidth-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = RateWidth'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[QuoWidth-2:0], 1'b1};
         end else begin
            rem_in = trial[RateWidth-1:0];
            quo_in = {quo_ff[QuoWidth-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign result.valid = done_ff;
   assign result.quo   = quo_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff) else $error("divider done while running");
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff)) else $error("divider done without run");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> cnt_ff <= 5'(RateWidth - 1)) else $error("divider count out of range");
endmodule

// ===== rtl/ubds_error_pipe.sv =====
// Pipeline that scores one modulation pattern per cycle over a whole frame.
// Stages: count build, products, absolute errors, worst-of reduction.
// Depends on ubds_pkg.
module ubds_error_pipe #(
   parameter int BitsPerFrame = ubds_pkg::DefBitsFrame
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [ubds_pkg::PatWidth-1:0]  in_pat,
   input  logic [ubds_pkg::PrescWidth-1:0] divisor_n,
   input  logic [ubds_pkg::RateWidth-1:0] clock_hz,
   input  logic [ubds_pkg::RateWidth-1:0] baud,
   output logic                           out_valid,
   output logic [ubds_pkg::PatWidth-1:0]  out_pat,
   output logic [ubds_pkg::ErrWidth-1:0]  out_err
);
   import ubds_pkg::*;

   localparam int NumPairs = (BitsPerFrame + 1) / 2;

   logic [3:0]            vld_ff;
   logic [PatWidth-1:0]   pat1_ff, pat2_ff, pat3_ff, pat4_ff;
   logic [CountWidth-1:0] cnt1_ff [BitsPerFrame];
   logic [ErrWidth-1:0]   act2_ff [BitsPerFrame];
   logic [ErrWidth-1:0]   err3_ff [NumPairs];
   logic [ErrWidth-1:0]   err4_ff;
   logic [CountWidth-1:0] cnt1_in [BitsPerFrame];
   logic [ErrWidth-1:0]   err3_in [NumPairs];
   logic [ErrWidth-1:0]   err4_in;
   logic [ErrWidth-1:0]   diff [BitsPerFrame];
   logic [ErrWidth-1:0]   ideal;

   // Clock count after bit time i is (i+1)*N plus the pattern ones seen so far.
   // The pattern is read MSB first and wraps every eight.
   always_comb begin
      logic [3:0] ones;
      ones = '0;
      for (int i = 0; i < BitsPerFrame; i++) begin
         ones = ones + 4'(in_pat[PatWidth-1-(i % PatWidth)]);
         cnt1_in[i] = CountWidth'(i + 1) * CountWidth'(divisor_n) + CountWidth'(ones);
      end
   end

   always_comb begin
      for (int i = 0; i < BitsPerFrame; i++) begin
         ideal   = ErrWidth'(i + 1) * ErrWidth'(clock_hz);
         diff[i] = (ideal >= act2_ff[i]) ? ideal - act2_ff[i] : act2_ff[i] - ideal;
      end
      for (int j = 0; j < NumPairs; j++) begin
         if (2 * j + 1 < BitsPerFrame)
            err3_in[j] = (diff[2*j] > diff[2*j+1]) ? diff[2*j] : diff[2*j+1];
         else
            err3_in[j] = diff[2*j];
      end
      err4_in = '0;
      for (int j = 0; j < NumPairs; j++)
         if (err3_ff[j] > err4_in) err4_in = err3_ff[j];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
      pat1_ff <= in_pat;
      pat2_ff <= pat1_ff;
      pat3_ff <= pat2_ff;
      pat4_ff <= pat3_ff;
      for (int i = 0; i < BitsPerFrame; i++) begin
         cnt1_ff[i] <= cnt1_in[i];
         act2_ff[i] <= ErrWidth'(cnt1_ff[i]) * ErrWidth'(baud);
      end
      for (int j = 0; j < NumPairs; j++) err3_ff[j] <= err3_in[j];
      err4_ff <= err4_in;
   end

   assign out_valid = vld_ff[3];
   assign out_pat   = pat4_ff;
   assign out_err   = err4_ff;

   a_pat_order: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] && vld_ff[2] |-> pat3_ff == pat4_ff + 8'd1)
      else $error("patterns out of order");
   a_vld_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(vld_ff)) else $error("pipeline valid bits unknown");
   a_out_follows: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(vld_ff[2])) else $error("output valid without stage three");
endmodule

// ===== rtl/uart_baud_divisor_search_unit.sv =====
// UART baud divisor search: top level with control, divider and pattern search.
// Depends on ubds_pkg, ubds_divider and ubds_error_pipe.
//
//   channel   | ports                          | handshake
//   request   | req_baud_rate                  | start, busy
//   response  | rsp_valid_res .. rsp_second_mod| rsp_strobe, one cycle
//   config    | csr_clock_hz                   | csr_write
//
// An item runs the divider, then scores all 256 patterns through the
// 4-stage error pipeline; the single scoring pipeline sets most of its length.
// Requests with a zero baud rate or one above the clock go from the check state straight to the output state.
// Synchronous active-high reset; clock_hz resets to 3000000.
// busy is high from acceptance until the result strobe; results cannot stall.
module uart_baud_divisor_search_unit #(
   parameter int BitsPerFrame = ubds_pkg::DefBitsFrame
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ubds_pkg::RateWidth-1:0]  req_baud_rate,
   input  logic                            csr_write,
   input  logic [ubds_pkg::RateWidth-1:0]  csr_clock_hz,
   output logic                            rsp_strobe,
   output logic                            rsp_valid_res,
   output logic                            rsp_oversample,
   output logic [ubds_pkg::PrescWidth-1:0] rsp_prescaler,
   output logic [3:0]                      rsp_first_mod,
   output logic [ubds_pkg::PatWidth-1:0]   rsp_second_mod
);
   import ubds_pkg::*;

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StChk  = 3'd1;
   localparam logic [2:0] StDiv  = 3'd2;
   localparam logic [2:0] StRun  = 3'd3;
   localparam logic [2:0] StOut  = 3'd4;

   logic [2:0]            st_ff, st_in;
   logic [RateWidth-1:0]  clk_hz_ff, baud_ff;
   logic [PrescWidth-1:0] n_ff;
   logic [PatWidth:0]     pat_ff, pat_in;
   logic                  ok_ff;
   logic [ErrWidth-1:0]   best_ff;
   logic [PatWidth-1:0]   best_pat_ff;
   logic                  strobe_ff;
   logic                  div_start;
   div_res_type           div_res;
   logic                  p_valid;
   logic [PatWidth-1:0]   p_pat;
   logic [ErrWidth-1:0]   p_err;
   logic                  feed;

   ubds_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(clk_hz_ff), .divisor(baud_ff), .result(div_res));

   assign feed = (st_ff == StRun) && !pat_ff[PatWidth];

   ubds_error_pipe #(.BitsPerFrame(BitsPerFrame)) u_pipe (
      .clock(clock), .reset(reset), .in_valid(feed), .in_pat(pat_ff[PatWidth-1:0]),
      .divisor_n(n_ff), .clock_hz(clk_hz_ff), .baud(baud_ff),
      .out_valid(p_valid), .out_pat(p_pat), .out_err(p_err));

   assign div_start = (st_ff == StChk) && (baud_ff != '0) && (baud_ff <= clk_hz_ff);

   always_comb begin
      st_in  = st_ff;
      pat_in = pat_ff;
      unique case (st_ff)
         StIdle: if (start) st_in = StChk;
         StChk: begin
            st_in = div_start ? StDiv : StOut;
         end
         StDiv: begin
            pat_in = '0;
            if (div_res.valid) st_in = (div_res.quo > QuoWidth'(16'hFFFF)) ? StOut : StRun;
         end
         StRun: begin
            if (feed) pat_in = pat_ff + 1'b1;
            if (p_valid && p_pat == '1) st_in = StOut;
         end
         StOut: st_in = StIdle;
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= StIdle;
         clk_hz_ff <= ClockReset;
         strobe_ff <= 1'b0;
         ok_ff     <= 1'b0;
      end else begin
         st_ff     <= st_in;
         strobe_ff <= (st_ff == StOut);
         if (csr_write) clk_hz_ff <= csr_clock_hz;
         if (st_ff == StIdle && start) ok_ff <= 1'b0;
         if (st_ff == StDiv && div_res.valid && div_res.quo <= QuoWidth'(16'hFFFF))
            ok_ff <= 1'b1;
      end
      pat_ff <= pat_in;
      if (st_ff == StIdle && start) baud_ff <= req_baud_rate;
      if (st_ff == StDiv && div_res.valid) n_ff <= div_res.quo[PrescWidth-1:0];
      if (p_valid && (p_pat == '0 || p_err < best_ff)) begin
         best_ff     <= p_err;
         best_pat_ff <= p_pat;
      end
   end

   assign busy           = (st_ff != StIdle);
   assign rsp_strobe     = strobe_ff;
   assign rsp_valid_res  = ok_ff;
   assign rsp_oversample = ok_ff && (n_ff >= PrescWidth'(PlainLimit));
   assign rsp_prescaler  = !ok_ff ? '0 : (rsp_oversample ? (n_ff >> 4) : n_ff);
   assign rsp_first_mod  = (ok_ff && rsp_oversample) ? n_ff[3:0] : 4'd0;
   assign rsp_second_mod = ok_ff ? best_pat_ff : '0;

   a_strobe_after_out: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(st_ff) == StOut) else $error("strobe without output state");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("strobe while busy");
   a_feed_in_run: assert property (@(posedge clock) disable iff (reset)
      feed |-> st_ff == StRun) else $error("pattern fed outside search");
endmodule
